[rtl/core/sbcd_pkg.sv]
// Shared types and constants of the sensor bank change detector.
package sbcd_pkg;

  localparam int TIME_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int POS_W      = 4;
  localparam int MOD_W      = 3;
  localparam int SNUM_W     = 5;
  localparam int LAG_W      = 16;
  localparam int IN_DATA_W  = 40;   // now_ticks, report_byte
  localparam int OUT_DATA_W = 48;   // module_index, sensor_number, is_on, event_time, pad

  localparam logic [LAG_W-1:0]  LAG_RESET   = 16'd6;
  localparam logic [SNUM_W-1:0] SENSOR_BASE = 5'd16;

  // req_type codes
  localparam logic REQ_POLL = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;       // input transfer this cycle
    logic poll_finish;  // poll state: form the midpoint stamp
    logic emit;         // load next event into the output register
  } sbcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_poll;      // current input item is a poll start
    logic evt_start;    // current input byte completes a changed word
    logic out_free;     // output register can take an event this cycle
    logic last_pick;    // event picked now is the final one of the word
  } sbcd_sts_t;

endpackage

[rtl/core/sbcd_ctrl.sv]
// Controller state machine: item acceptance, poll sequencing, event emission.
module sbcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sbcd_pkg::sbcd_sts_t sts,
  output sbcd_pkg::sbcd_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POLL,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd.accept      = 1'b0;
    cmd.poll_finish = 1'b0;
    cmd.emit        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.is_poll) begin
            state_nxt = ST_POLL;
          end else if (sts.evt_start) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_POLL: begin
        cmd.poll_finish = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_pick) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/sbcd_dp.sv]
// Datapath: word store, poll timing, change mask scan and output register.
module sbcd_dp #(
  parameter int NUM_MODULES = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_req_type,
  input  logic [sbcd_pkg::IN_DATA_W-1:0]   in_data,
  input  logic                             cfg_valid,
  input  logic [sbcd_pkg::LAG_W-1:0]       cfg_data,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic                             out_tlast,
  output logic [sbcd_pkg::OUT_DATA_W-1:0]  out_data,
  input  sbcd_pkg::sbcd_cmd_t              cmd,
  output sbcd_pkg::sbcd_sts_t              sts
);

  localparam int CW = $clog2(NUM_MODULES + 1);
  localparam int IW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam logic [CW-1:0] CUR_END = CW'(NUM_MODULES);

  logic [sbcd_pkg::WORD_W-1:0] prev_words_r [NUM_MODULES];
  logic [sbcd_pkg::BYTE_W-1:0] high_byte_r;
  logic                        phase_r;
  logic [CW-1:0]               cursor_r;
  logic [sbcd_pkg::TIME_W-1:0] poll_time_r;
  logic [sbcd_pkg::TIME_W-1:0] stamp_r;
  logic                        seen_r;
  logic [sbcd_pkg::LAG_W-1:0]  lag_r;
  logic [sbcd_pkg::TIME_W-1:0] prev_time_r;
  logic [sbcd_pkg::TIME_W-1:0] now_r;
  logic [sbcd_pkg::WORD_W-1:0] diff_r;
  logic [sbcd_pkg::WORD_W-1:0] word_r;
  logic [sbcd_pkg::MOD_W-1:0]  evt_mod_r;

  logic                         out_valid_r;
  logic                         out_last_r;
  logic [sbcd_pkg::MOD_W-1:0]   out_mod_r;
  logic [sbcd_pkg::SNUM_W-1:0]  out_snum_r;
  logic                         out_on_r;
  logic [sbcd_pkg::TIME_W-1:0]  out_time_r;

  logic [sbcd_pkg::TIME_W-1:0] now_ticks;
  logic [sbcd_pkg::BYTE_W-1:0] rpt_byte;
  logic [sbcd_pkg::WORD_W-1:0] new_word;
  logic [sbcd_pkg::WORD_W-1:0] new_diff;
  logic [sbcd_pkg::WORD_W-1:0] diff_rest;
  logic [sbcd_pkg::POS_W-1:0]  pick_pos;
  logic [sbcd_pkg::TIME_W:0]   mid_sum;
  logic [IW-1:0]               cur_idx;
  logic                        in_range;

  assign now_ticks = in_data[sbcd_pkg::TIME_W-1:0];
  assign rpt_byte  = in_data[sbcd_pkg::TIME_W +: sbcd_pkg::BYTE_W];
  assign cur_idx   = cursor_r[IW-1:0];
  assign in_range  = (cursor_r < CUR_END);
  assign new_word  = {high_byte_r, rpt_byte};
  assign new_diff  = new_word ^ prev_words_r[cur_idx];
  assign mid_sum   = {1'b0, prev_time_r} + {1'b0, now_r};

  // highest set bit of the remaining change mask
  always_comb begin
    pick_pos = '0;
    for (int i = 0; i < sbcd_pkg::WORD_W; i++) begin
      if (diff_r[i]) begin
        pick_pos = sbcd_pkg::POS_W'(i);
      end
    end
  end

  assign diff_rest = diff_r & ~(sbcd_pkg::WORD_W'(1) << pick_pos);

  assign sts.is_poll   = (in_req_type == sbcd_pkg::REQ_POLL);
  assign sts.evt_start = (in_req_type == sbcd_pkg::REQ_BYTE) && in_range && phase_r
                         && (new_diff != '0);
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.last_pick = (diff_rest == '0);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NUM_MODULES; m++) begin
        prev_words_r[m] <= '0;
      end
      high_byte_r <= '0;
      phase_r     <= 1'b0;
      cursor_r    <= '0;
      poll_time_r <= '0;
      stamp_r     <= '0;
      seen_r      <= 1'b0;
      lag_r       <= sbcd_pkg::LAG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        lag_r <= cfg_data;
      end
      if (cmd.accept) begin
        if (in_req_type == sbcd_pkg::REQ_POLL) begin
          poll_time_r <= now_ticks;
          seen_r      <= 1'b1;
          cursor_r    <= '0;
          phase_r     <= 1'b0;
        end else if (in_range) begin
          if (!phase_r) begin
            high_byte_r <= rpt_byte;
            phase_r     <= 1'b1;
          end else begin
            prev_words_r[cur_idx] <= new_word;
            phase_r               <= 1'b0;
            cursor_r              <= cursor_r + CW'(1);
          end
        end
      end
      if (cmd.poll_finish) begin
        stamp_r <= mid_sum[sbcd_pkg::TIME_W:1];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_req_type == sbcd_pkg::REQ_POLL) begin
        prev_time_r <= seen_r ? poll_time_r
                              : now_ticks - sbcd_pkg::TIME_W'(lag_r);
        now_r       <= now_ticks;
      end else begin
        diff_r    <= new_diff;
        word_r    <= new_word;
        evt_mod_r <= sbcd_pkg::MOD_W'(cursor_r);
      end
    end else if (cmd.emit) begin
      diff_r <= diff_rest;
    end
    if (cmd.emit) begin
      out_mod_r  <= evt_mod_r;
      out_snum_r <= sbcd_pkg::SENSOR_BASE - sbcd_pkg::SNUM_W'(pick_pos);
      out_on_r   <= word_r[pick_pos];
      out_time_r <= stamp_r;
      out_last_r <= (diff_rest == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_data   = {7'd0, out_time_r, out_on_r, out_snum_r, out_mod_r};

endmodule

[rtl/core/sensor_bank_change_detector_top.sv]
// Top level of the sensor bank change detector.
// A poll start holds the input through the poll state; an upper byte or an ignored byte
// does not; a lower byte holds it while its changed sensors (1..16) are emitted.
// The events of a lower byte are loaded into the output register from the emit state,
// one event per cycle while the output is free; the bit scan of the change mask sets that pace.
// Reset (rst_n, synchronous, active low) clears the stored words, poll state, the lag
// register (to 6) and the output valid flag.
module sensor_bank_change_detector_top #(
  parameter int NUM_MODULES = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sbcd_pkg::IN_DATA_W-1:0]   in_tdata,   // [31:0] now_ticks, [39:32] report_byte
  input  logic                             in_tuser,   // [0] req_type
  // lag register write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbcd_pkg::LAG_W-1:0]       cfg_data,   // initial_lag_ticks
  // event channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sbcd_pkg::OUT_DATA_W-1:0]  out_tdata,  // [2:0] module_index,
                                                       // [7:3] sensor_number, [8] is_on,
                                                       // [40:9] event_time, rest zero
  output logic                             out_tlast   // last_event
);

  sbcd_pkg::sbcd_cmd_t cmd;
  sbcd_pkg::sbcd_sts_t sts;

  // Register writes load lag_r; the user must issue them only while idle; not enforced here.
  assign cfg_ready = 1'b1;

  // Sequencer: accepts items, runs the poll state and paces event emission.
  sbcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Word store, midpoint timing, change-mask scan and the output register. The output
  // register lets the last event of a word wait while the next item transfers.
  sbcd_dp #(
    .NUM_MODULES (NUM_MODULES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req_type (in_tuser),
    .in_data     (in_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tlast   (out_tlast),
    .out_data    (out_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
